[rtl/core/cca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_pkg
// Shared constants of the cross-correlation accumulator.
// ----------------------------------------------------------------------------
package cca_pkg;

    // default sizing
    localparam int MAX_ANTENNAS_DEF = 16;
    localparam int MAX_BINS_DEF     = 256;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int ACC_BITS_DEF     = 48;

    // fixed field widths
    localparam int IDX_W     = 15;
    localparam int ANT_CFG_W = 5;
    localparam int BIN_CFG_W = 9;
    localparam int CFG_DW    = 9;
    localparam int CFG_IW    = 1;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_ANTENNA_COUNT = 1'd0;
    localparam logic [CFG_IW-1:0] REG_BIN_COUNT     = 1'd1;

    // transfer kinds on the input channel
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // register reset values
    localparam int ANT_RST     = 2;
    localparam int BIN_RST_CAP = 256;

endpackage : cca_pkg
`default_nettype wire

[rtl/core/cross_correlation_accumulator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cross_correlation_accumulator
// X stage of an FX correlator: per-bin complex cross products of every
// antenna pair, accumulated with saturation in a visibility memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           contents
//  s_*       in         tvalid/tready       sample push or visibility read
//  m_*       out        tvalid/tready       visibility read result
//  cfg_*     in         write enable only   antenna_count, bin_count
//
//  A push for antenna 0 is taken in the idle state; a push for antenna j > 0
//  issues one multiply-accumulate per earlier antenna through the
//  accumulator memory, then waits for the p1, p2, p3 pipeline to drain.
//  A read passes through ST_RD and ST_RD_OUT and waits in ST_RD_OUT while
//  an earlier result still sits in the output register with m_tready low.
//  After reset a clearing pass zeroes the accumulator memory, one entry a
//  cycle (MAX_ANTENNAS*(MAX_ANTENNAS-1)/2*MAX_BINS entries, 30720 by default).
//  A configuration write then holds s_tready low while the limits catch up.
// ----------------------------------------------------------------------------
module cross_correlation_accumulator
    import cca_pkg::*;
#(
    parameter int MAX_ANTENNAS = MAX_ANTENNAS_DEF,
    parameter int MAX_BINS     = MAX_BINS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int ACC_BITS     = ACC_BITS_DEF
)
(
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          s_tvalid,
    output logic                                         s_tready,
    // sample_real, sample_imag, read_index, clear_after_read
    input  wire  [((2*SAMPLE_BITS+IDX_W+1+7)/8)*8-1:0]   s_tdata,
    // func
    input  wire  [0:0]                                   s_tuser,
    output logic                                         m_tvalid,
    input  wire                                          m_tready,
    // vis_real, vis_imag
    output logic [((2*ACC_BITS+7)/8)*8-1:0]              m_tdata,
    // index_valid
    output logic [0:0]                                   m_tuser,
    input  wire                                          cfg_we,
    input  wire  [CFG_IW-1:0]                            cfg_index,
    input  wire  [CFG_DW-1:0]                            cfg_data
);

    localparam int S           = SAMPLE_BITS;
    localparam int OUT_DW      = ((2*ACC_BITS+7)/8)*8;
    localparam int NUM_PAIRS   = MAX_ANTENNAS * (MAX_ANTENNAS - 1) / 2;
    localparam int ACC_DEPTH   = NUM_PAIRS * MAX_BINS;
    localparam int STORE_DEPTH = MAX_ANTENNAS * MAX_BINS;
    localparam int ACC_AW      = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ANT_W       = $clog2(MAX_ANTENNAS);
    localparam int BIN_W       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int ANT_CNT_W   = $clog2(MAX_ANTENNAS + 1);
    localparam int BIN_CNT_W   = $clog2(MAX_BINS + 1);
    localparam int PAIR_W      = $clog2(NUM_PAIRS + 1);
    localparam int LIM_W       = $clog2(ACC_DEPTH + 1);
    localparam int MADDR_W     = PAIR_W + BIN_CNT_W + 1;
    localparam int CMP_W       = ((LIM_W > IDX_W) ? LIM_W : IDX_W) + 1;
    localparam int IDXX_W      = (ACC_AW > IDX_W) ? ACC_AW : IDX_W;
    localparam int PROD_W      = 2 * S;
    localparam int TERM_W      = 2 * S + 1;
    localparam int SUM_W       = ((ACC_BITS > TERM_W) ? ACC_BITS : TERM_W) + 1;
    localparam int BIN_RST     = (MAX_BINS < BIN_RST_CAP) ? MAX_BINS : BIN_RST_CAP;

    localparam logic signed [SUM_W-1:0] ACC_MAX = (SUM_W'(1) <<< (ACC_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MAC    = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_RD_OUT = 3'd4;

    // memories
    logic [2*S-1:0]        store_mem [STORE_DEPTH];
    logic [2*ACC_BITS-1:0] acc_mem   [ACC_DEPTH];

    logic [2:0]            state_reg, state_next;
    logic [ACC_AW-1:0]     clr_addr_reg;
    logic [1:0]            settle_reg;

    // configuration and derived limits
    logic [ANT_CNT_W-1:0]  n_reg;
    logic [BIN_CNT_W-1:0]  bins_reg;
    logic [PAIR_W-1:0]     pairs_reg;
    logic [LIM_W-1:0]      limit_reg;

    // position in the frame
    logic [ANT_W-1:0]      ant_ctr_reg;
    logic [BIN_W-1:0]      bin_ctr_reg;

    // item being worked on
    logic [ANT_W-1:0]      j_reg;
    logic [BIN_W-1:0]      f_reg;
    logic signed [S-1:0]   br_reg, bi_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  clr_req_reg;

    // multiply-accumulate issue
    logic [ANT_W-1:0]      i_reg;
    logic [PAIR_W-1:0]     pair_reg;
    logic                  issue_done_reg;
    logic                  issue;
    logic [ANT_CNT_W-1:0]  pair_step;
    logic [MADDR_W-1:0]    mac_addr_full;
    logic [ACC_AW-1:0]     mac_addr;

    // pipeline
    logic                          p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [ACC_AW-1:0]             p1_addr_reg, p2_addr_reg, p3_addr_reg;
    logic signed [PROD_W-1:0]      prod_rr_reg, prod_ii_reg, prod_ir_reg, prod_ri_reg;
    logic signed [ACC_BITS-1:0]    acc_re_p2_reg, acc_im_p2_reg;
    logic signed [ACC_BITS-1:0]    acc_re_p3_reg, acc_im_p3_reg;
    logic signed [TERM_W-1:0]      term_re_reg, term_im_reg;
    logic signed [SUM_W-1:0]       sum_re, sum_im;
    logic signed [ACC_BITS-1:0]    new_re, new_im;

    // memory ports
    logic                  st_we, st_re;
    logic [STORE_AW-1:0]   st_waddr, st_raddr;
    logic [2*S-1:0]        st_rd_reg;
    logic                  acc_we, acc_re;
    logic [ACC_AW-1:0]     acc_waddr, acc_raddr;
    logic [2*ACC_BITS-1:0] acc_wdata;
    logic [2*ACC_BITS-1:0] acc_rd_reg;

    // output register
    logic                  m_valid_reg;
    logic [ACC_BITS-1:0]   out_re_reg, out_im_reg;
    logic                  out_user_reg;
    logic                  out_free;

    // read path
    logic [IDXX_W-1:0]     idx_x;
    logic                  idx_ok;

    // input transfer
    logic                  in_xfer;
    logic                  in_func;
    logic signed [S-1:0]   in_re, in_im;
    logic [IDX_W-1:0]      in_idx;
    logic                  in_clr;

    // configuration clamp
    logic [ANT_CFG_W-1:0]  cfg_ant_v;
    logic [BIN_CFG_W-1:0]  cfg_bin_v;
    logic [ANT_CNT_W-1:0]  n_cfg;
    logic [BIN_CNT_W-1:0]  bins_cfg;

    assign in_func  = s_tuser[0];
    assign in_re    = s_tdata[S-1:0];
    assign in_im    = s_tdata[2*S-1:S];
    assign in_idx   = s_tdata[2*S+IDX_W-1:2*S];
    assign in_clr   = s_tdata[2*S+IDX_W];

    assign s_tready = (state_reg == ST_IDLE) && (settle_reg == 2'd0);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DW'({out_im_reg, out_re_reg});
    assign m_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_comb
    begin
        cfg_ant_v = cfg_data[ANT_CFG_W-1:0];
        cfg_bin_v = cfg_data[BIN_CFG_W-1:0];
        if (cfg_ant_v < ANT_CFG_W'(2))
            n_cfg = ANT_CNT_W'(2);
        else if (32'(cfg_ant_v) > MAX_ANTENNAS)
            n_cfg = ANT_CNT_W'(MAX_ANTENNAS);
        else
            n_cfg = ANT_CNT_W'(cfg_ant_v);
        if (cfg_bin_v == '0)
            bins_cfg = BIN_CNT_W'(1);
        else if (32'(cfg_bin_v) > MAX_BINS)
            bins_cfg = BIN_CNT_W'(MAX_BINS);
        else
            bins_cfg = BIN_CNT_W'(cfg_bin_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= ANT_CNT_W'(ANT_RST);
            bins_reg   <= BIN_CNT_W'(BIN_RST);
            pairs_reg  <= PAIR_W'(1);
            limit_reg  <= LIM_W'(BIN_RST);
            settle_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ANTENNA_COUNT: n_reg    <= n_cfg;
                    REG_BIN_COUNT:     bins_reg <= bins_cfg;
                    default:           ;
                endcase
                settle_reg <= 2'd2;
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
            // limits follow the registers, pairs_reg first and limit_reg after it
            pairs_reg <= PAIR_W'((2*ANT_CNT_W)'(n_reg) * (2*ANT_CNT_W)'(n_reg - ANT_CNT_W'(1))
                                 >> 1);
            limit_reg <= LIM_W'((PAIR_W + BIN_CNT_W)'(pairs_reg)
                                * (PAIR_W + BIN_CNT_W)'(bins_reg));
        end
    end

    // ------------------------------------------------------------------
    // frame position
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ant_ctr_reg <= '0;
            bin_ctr_reg <= '0;
        end
        else if (cfg_we)
        begin
            ant_ctr_reg <= '0;
            bin_ctr_reg <= '0;
        end
        else if (in_xfer && in_func == FUNC_PUSH)
        begin
            if (BIN_CNT_W'(bin_ctr_reg) + BIN_CNT_W'(1) >= bins_reg)
            begin
                bin_ctr_reg <= '0;
                if (ANT_CNT_W'(ant_ctr_reg) + ANT_CNT_W'(1) >= n_reg)
                    ant_ctr_reg <= '0;
                else
                    ant_ctr_reg <= ant_ctr_reg + ANT_W'(1);
            end
            else
            begin
                bin_ctr_reg <= bin_ctr_reg + BIN_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign issue     = (state_reg == ST_MAC) && !issue_done_reg;
    assign pair_step = n_reg - ANT_CNT_W'(i_reg) - ANT_CNT_W'(2);
    assign mac_addr_full = MADDR_W'(pair_reg) * MADDR_W'(bins_reg) + MADDR_W'(f_reg);
    assign mac_addr  = mac_addr_full[ACC_AW-1:0];

    always_comb
    begin
        idx_x  = IDXX_W'(idx_reg);
        idx_ok = (CMP_W'(idx_reg) < CMP_W'(limit_reg))
              && (CMP_W'(idx_reg) < CMP_W'(ACC_DEPTH));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == ACC_AW'(ACC_DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_xfer)
                begin
                    if (in_func == FUNC_READ)
                        state_next = ST_RD;
                    else if (ant_ctr_reg != '0)
                        state_next = ST_MAC;
                end
            ST_MAC:
                if (issue_done_reg && !p1_valid_reg && !p2_valid_reg && !p3_valid_reg)
                    state_next = ST_IDLE;
            ST_RD:
                state_next = ST_RD_OUT;
            ST_RD_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            issue_done_reg <= 1'b1;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + ACC_AW'(1);
            if (in_xfer && in_func == FUNC_PUSH && ant_ctr_reg != '0)
                issue_done_reg <= 1'b0;
            else if (issue && i_reg == j_reg - ANT_W'(1))
                issue_done_reg <= 1'b1;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (state_reg == ST_RD_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // item and issue registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            j_reg       <= ant_ctr_reg;
            f_reg       <= bin_ctr_reg;
            br_reg      <= in_re;
            bi_reg      <= in_im;
            idx_reg     <= in_idx;
            clr_req_reg <= in_clr;
            i_reg       <= '0;
            pair_reg    <= PAIR_W'(ant_ctr_reg) - PAIR_W'(1);
        end
        else if (issue)
        begin
            i_reg    <= i_reg + ANT_W'(1);
            pair_reg <= pair_reg + PAIR_W'(pair_step);
        end
    end

    // ------------------------------------------------------------------
    // multiply-accumulate pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        p1_addr_reg   <= mac_addr;
        // stage 2: products of held and arriving samples
        prod_rr_reg   <= $signed(st_rd_reg[S-1:0])   * br_reg;
        prod_ii_reg   <= $signed(st_rd_reg[2*S-1:S]) * bi_reg;
        prod_ir_reg   <= $signed(st_rd_reg[2*S-1:S]) * br_reg;
        prod_ri_reg   <= $signed(st_rd_reg[S-1:0])   * bi_reg;
        acc_re_p2_reg <= acc_rd_reg[ACC_BITS-1:0];
        acc_im_p2_reg <= acc_rd_reg[2*ACC_BITS-1:ACC_BITS];
        p2_addr_reg   <= p1_addr_reg;
        // stage 3: x_i * conj(x_j)
        term_re_reg   <= TERM_W'(prod_rr_reg) + TERM_W'(prod_ii_reg);
        term_im_reg   <= TERM_W'(prod_ir_reg) - TERM_W'(prod_ri_reg);
        acc_re_p3_reg <= acc_re_p2_reg;
        acc_im_p3_reg <= acc_im_p2_reg;
        p3_addr_reg   <= p2_addr_reg;
    end

    // saturating add ahead of write-back
    always_comb
    begin
        sum_re = SUM_W'(acc_re_p3_reg) + SUM_W'(term_re_reg);
        sum_im = SUM_W'(acc_im_p3_reg) + SUM_W'(term_im_reg);
        if (sum_re > ACC_MAX)
            new_re = ACC_MAX[ACC_BITS-1:0];
        else if (sum_re < ACC_MIN)
            new_re = ACC_MIN[ACC_BITS-1:0];
        else
            new_re = sum_re[ACC_BITS-1:0];
        if (sum_im > ACC_MAX)
            new_im = ACC_MAX[ACC_BITS-1:0];
        else if (sum_im < ACC_MIN)
            new_im = ACC_MIN[ACC_BITS-1:0];
        else
            new_im = sum_im[ACC_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // memory ports
    // ------------------------------------------------------------------
    always_comb
    begin
        st_we    = in_xfer && in_func == FUNC_PUSH;
        st_waddr = STORE_AW'(ant_ctr_reg) * STORE_AW'(MAX_BINS) + STORE_AW'(bin_ctr_reg);
        st_re    = issue;
        st_raddr = STORE_AW'(i_reg) * STORE_AW'(MAX_BINS) + STORE_AW'(f_reg);

        acc_re    = issue || state_reg == ST_RD;
        acc_raddr = issue ? mac_addr : idx_x[ACC_AW-1:0];

        acc_we    = 1'b0;
        acc_waddr = clr_addr_reg;
        acc_wdata = '0;
        priority if (state_reg == ST_CLEAR)
        begin
            acc_we = 1'b1;
        end
        else if (p3_valid_reg)
        begin
            acc_we    = 1'b1;
            acc_waddr = p3_addr_reg;
            acc_wdata = {new_im, new_re};
        end
        else if (state_reg == ST_RD_OUT && out_free && idx_ok && clr_req_reg)
        begin
            // clear after read
            acc_we    = 1'b1;
            acc_waddr = idx_x[ACC_AW-1:0];
        end
        else
        begin
            acc_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= {in_im, in_re};
        if (st_re)
            st_rd_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        if (acc_re)
            acc_rd_reg <= acc_mem[acc_raddr];
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD_OUT && out_free)
        begin
            out_re_reg   <= idx_ok ? acc_rd_reg[ACC_BITS-1:0] : '0;
            out_im_reg   <= idx_ok ? acc_rd_reg[2*ACC_BITS-1:ACC_BITS] : '0;
            out_user_reg <= idx_ok;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("input taken during clearing pass");

    a_writeback_only_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg |-> state_reg == ST_MAC)
        else $error("accumulator write-back outside multiply-accumulate");

    a_issue_below_current: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> i_reg < j_reg)
        else $error("issue for an antenna not earlier than the arriving one");

    a_invalid_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid read result carries data");

endmodule : cross_correlation_accumulator
`default_nettype wire

[bench/tb_cross_correlation_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cross_correlation_accumulator
// Self-checking bench for the correlator X stage. Sample pushes and
// visibility reads go in on the input stream. A bit-exact model of the
// sample store and of the saturating visibility memory tracks every transfer.
// Each read result is compared field by field with the model's value.
// ----------------------------------------------------------------------------
module tb_cross_correlation_accumulator
    import cca_pkg::*;
();

    localparam int S_DW = ((2*SAMPLE_BITS_DEF+IDX_W+1+7)/8)*8;
    localparam int M_DW = ((2*ACC_BITS_DEF+7)/8)*8;
    localparam int N_ANT = MAX_ANTENNAS_DEF;
    localparam int N_BIN = MAX_BINS_DEF;
    localparam int VIS_DEPTH = N_ANT*(N_ANT-1)/2*N_BIN;
    localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam logic [15:0] S_MIN = 16'h8000;
    localparam logic [15:0] S_MAX = 16'h7FFF;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 150000;

    typedef struct {
        logic [47:0] re;
        logic [47:0] im;
        logic        valid;
    } vis_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DW-1:0]     s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DW-1:0]     m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;

    // model of the block
    logic signed [15:0] held_re [0:N_ANT*N_BIN-1];
    logic signed [15:0] held_im [0:N_ANT*N_BIN-1];
    longint             vis_re [0:VIS_DEPTH-1];
    longint             vis_im [0:VIS_DEPTH-1];
    int unsigned        ant_ptr;
    int unsigned        bin_ptr;
    int unsigned        n_ant;
    int unsigned        n_bin;

    vis_t        vis_expected [$];
    int unsigned mismatch_count;
    bit          gaps_on;
    int unsigned sink_hold_cycles;
    int unsigned idle_cycles;

    cross_correlation_accumulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void clear_model();
        int unsigned k;
        for (k = 0; k < N_ANT*N_BIN; k++)
        begin
            held_re[k] = '0;
            held_im[k] = '0;
        end
        for (k = 0; k < VIS_DEPTH; k++)
        begin
            vis_re[k] = 0;
            vis_im[k] = 0;
        end
        ant_ptr = 0;
        bin_ptr = 0;
        n_ant = ANT_RST;
        n_bin = (N_BIN < BIN_RST_CAP) ? N_BIN : BIN_RST_CAP;
    endfunction

    function automatic longint sat_sum(longint acc, longint delta);
        longint total;
        total = acc + delta;
        if (total > ACC_MAX)
            total = ACC_MAX;
        else if (total < ACC_MIN)
            total = ACC_MIN;
        return total;
    endfunction

    function automatic void apply_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
        int unsigned v;
        if (idx == REG_ANTENNA_COUNT)
        begin
            v = 32'(value[ANT_CFG_W-1:0]);
            n_ant = (v < 2) ? 2 : (v > N_ANT) ? N_ANT : v;
        end
        else
        begin
            v = 32'(value[BIN_CFG_W-1:0]);
            n_bin = (v < 1) ? 1 : (v > N_BIN) ? N_BIN : v;
        end
        // any write restarts the frame
        ant_ptr = 0;
        bin_ptr = 0;
    endfunction

    // cross products of the arriving sample with every earlier antenna
    function automatic void correlate_sample(logic signed [15:0] br, logic signed [15:0] bi);
        int unsigned i;
        int unsigned slot;
        int unsigned addr;
        longint ar;
        longint ai;
        longint xr;
        longint xi;
        xr = br;
        xi = bi;
        for (i = 0; i < ant_ptr; i++)
        begin
            slot = i*N_BIN + bin_ptr;
            addr = (i*n_ant - (i*(i+1))/2 + (ant_ptr - i - 1))*n_bin + bin_ptr;
            ar = held_re[slot];
            ai = held_im[slot];
            vis_re[addr] = sat_sum(vis_re[addr], ar*xr + ai*xi);
            vis_im[addr] = sat_sum(vis_im[addr], ai*xr - ar*xi);
        end
        held_re[ant_ptr*N_BIN + bin_ptr] = br;
        held_im[ant_ptr*N_BIN + bin_ptr] = bi;
        bin_ptr++;
        if (bin_ptr >= n_bin)
        begin
            bin_ptr = 0;
            ant_ptr++;
            if (ant_ptr >= n_ant)
                ant_ptr = 0;
        end
    endfunction

    function automatic vis_t fetch_visibility(logic [IDX_W-1:0] idx, logic clr);
        vis_t v;
        if (idx < n_ant*(n_ant-1)/2*n_bin)
        begin
            v.re = vis_re[idx][47:0];
            v.im = vis_im[idx][47:0];
            v.valid = 1'b1;
            if (clr)
            begin
                vis_re[idx] = 0;
                vis_im[idx] = 0;
            end
        end
        else
        begin
            v.re = '0;
            v.im = '0;
            v.valid = 1'b0;
        end
        return v;
    endfunction

    task automatic send_item(logic func, logic [15:0] re, logic [15:0] im,
                             logic [IDX_W-1:0] idx, logic clr);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {clr, idx, im, re};
        s_tuser <= func;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (func == FUNC_READ)
            vis_expected.push_back(fetch_visibility(idx, clr));
        else
            correlate_sample(re, im);
    endtask

    task automatic push(logic [15:0] re, logic [15:0] im);
        logic [IDX_W-1:0] junk_idx;
        logic             junk_clr;
        junk_idx = IDX_W'($urandom);
        junk_clr = 1'($urandom);
        send_item(FUNC_PUSH, re, im, junk_idx, junk_clr);
    endtask

    task automatic read(logic [IDX_W-1:0] idx, logic clr);
        logic [15:0] junk_re;
        logic [15:0] junk_im;
        junk_re = 16'($urandom);
        junk_im = 16'($urandom);
        send_item(FUNC_READ, junk_re, junk_im, idx, clr);
    endtask

    task automatic random_item();
        int unsigned limit;
        logic [15:0] re;
        logic [15:0] im;
        re = 16'($urandom);
        im = 16'($urandom);
        limit = n_ant*(n_ant-1)/2*n_bin;
        if ($urandom_range(0, 99) < 75)
            push(re, im);
        else if ($urandom_range(0, 99) < 85)
            read(IDX_W'($urandom_range(0, limit-1)), 1'($urandom_range(0, 1)));
        else
            read(IDX_W'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)));
    endtask

    // stop sending and let the block run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        while (vis_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        apply_register(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_state();
        // first transfer waits out the clearing pass
        read(15'd0, 1'b0);
        read(15'd255, 1'b1);
        read(15'd256, 1'b0);
        read(15'h7FFF, 1'b1);
    endtask

    task automatic test_frame_extremes();
        int unsigned k;
        settle();
        set_register(REG_ANTENNA_COUNT, 9'd3);
        set_register(REG_BIN_COUNT, 9'd2);
        push(S_MIN, S_MIN);
        push(S_MAX, S_MAX);
        push(S_MIN, S_MAX);
        push(S_MAX, S_MIN);
        push(16'hFFFF, 16'h0001);
        push(16'h0000, 16'h0000);
        // wrapped to antenna 0: second frame accumulates onto the first
        push(S_MAX, S_MAX);
        push(S_MIN, S_MIN);
        push(16'h0001, 16'hFFFF);
        push(S_MIN, S_MAX);
        push(S_MAX, S_MIN);
        push(S_MIN, S_MIN);
        for (k = 0; k < 6; k++)
            read(IDX_W'(k), (k % 2) == 0);
        read(15'd6, 1'b1);
        read(15'h7FFF, 1'b1);
        read(15'd0, 1'b0);
        read(15'd1, 1'b1);
        read(15'd1, 1'b0);
    endtask

    task automatic test_config_restart();
        int unsigned k;
        settle();
        set_register(REG_ANTENNA_COUNT, 9'd2);
        set_register(REG_BIN_COUNT, 9'd3);
        repeat (4) push(16'($urandom), 16'($urandom));
        settle();
        // rewriting the same value must still restart the frame
        set_register(REG_BIN_COUNT, 9'd3);
        repeat (6) push(16'($urandom), 16'($urandom));
        for (k = 0; k < 3; k++)
            read(IDX_W'(k), 1'b1);
    endtask

    task automatic test_random_settings();
        int unsigned ant_vals [7] = '{4, 16, 31, 2, 17, 496, 1};
        int unsigned bin_vals [7] = '{8, 1, 0, 511, 5, 16, 3};
        int unsigned counts [7] = '{180, 230, 140, 420, 180, 280, 140};
        int unsigned p;
        int unsigned n;
        for (p = 0; p < 7; p++)
        begin
            settle();
            set_register(REG_ANTENNA_COUNT, CFG_DW'(ant_vals[p]));
            set_register(REG_BIN_COUNT, CFG_DW'(bin_vals[p]));
            for (n = 0; n < counts[p]; n++)
            begin
                if (n % 64 == 0)
                    gaps_on = ($urandom_range(0, 3) != 0);
                random_item();
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        settle();
        set_register(REG_ANTENNA_COUNT, 9'd4);
        set_register(REG_BIN_COUNT, 9'd4);
        gaps_on = 1'b0;
        repeat (16) push(16'($urandom), 16'($urandom));
        // receiver stalls while reads keep coming, so the input backs up
        sink_hold_cycles = 300;
        repeat (20) read(IDX_W'($urandom_range(0, 23)), 1'($urandom_range(0, 1)));
        gaps_on = 1'b1;
        settle();
        repeat (20) random_item();
    endtask

    task automatic test_large_products();
        settle();
        set_register(REG_ANTENNA_COUNT, 9'd2);
        set_register(REG_BIN_COUNT, 9'd1);
        gaps_on = 1'b0;
        // largest positive products pile up on the single entry
        repeat (30)
        begin
            push(S_MIN, S_MIN);
            push(S_MIN, S_MIN);
        end
        read(15'd0, 1'b0);
        // largest negative real products
        repeat (10)
        begin
            push(S_MIN, S_MAX);
            push(S_MAX, S_MIN);
        end
        read(15'd0, 1'b0);
        push(S_MIN, S_MIN);
        push(S_MAX, S_MAX);
        read(15'd0, 1'b1);
        read(15'd0, 1'b0);
        gaps_on = 1'b1;
    endtask

    initial
    begin : result_check
        vis_t        want;
        int unsigned sink_wait;
        sink_wait = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (vis_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, got re %0d im %0d valid %0b", $time,
                             $signed(m_tdata[47:0]), $signed(m_tdata[95:48]), m_tuser[0]);
                    mismatch_count++;
                end
                else
                begin
                    want = vis_expected.pop_front();
                    if (m_tdata[47:0] !== want.re)
                    begin
                        $display("%0t: vis_real expected %0d, got %0d", $time,
                                 $signed(want.re), $signed(m_tdata[47:0]));
                        mismatch_count++;
                    end
                    if (m_tdata[95:48] !== want.im)
                    begin
                        $display("%0t: vis_imag expected %0d, got %0d", $time,
                                 $signed(want.im), $signed(m_tdata[95:48]));
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== want.valid)
                    begin
                        $display("%0t: index_valid expected %0b, got %0b", $time,
                                 want.valid, m_tuser[0]);
                        mismatch_count++;
                    end
                end
                sink_wait = gaps_on ? $urandom_range(0, 5) : 0;
            end
            if (sink_hold_cycles != 0)
            begin
                sink_wait = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (sink_wait != 0)
            begin
                m_tready <= 1'b0;
                sink_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : main
        idle_cycles = 0;
        mismatch_count = 0;
        sink_hold_cycles = 0;
        gaps_on = 1'b1;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= FUNC_PUSH;
        cfg_we <= 1'b0;
        cfg_index <= REG_ANTENNA_COUNT;
        cfg_data <= '0;
        clear_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_frame_extremes();
        test_config_restart();
        test_random_settings();
        test_backpressure();
        test_large_products();
        settle();
        if (mismatch_count == 0 && vis_expected.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cca_pkg.sv
rtl/core/cross_correlation_accumulator.sv
bench/tb_cross_correlation_accumulator.sv
